/* sv/tcw_pkg.sv */
package tcw_pkg;

    // screen geometry
    localparam int ROWS   = 25;
    localparam int COLS   = 80;
    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(CELLS);

    // fixed field widths
    localparam int CHAR_W      = 8;
    localparam int CELL_W      = 2 * CHAR_W;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int TAB_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // command queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [TAB_W-1:0]  RESET_TAB  = 4'd4;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB  = 2'd1;

    // command codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_PRINT = 3'd1;
    localparam logic [2:0] OP_LINE  = 3'd2;
    localparam logic [2:0] OP_TAB   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef struct packed {
        logic                   action;
        logic [CHAR_W-1:0]      char_code;
        logic [ROW_FIELD_W-1:0] read_row;
        logic [COL_FIELD_W-1:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] cursor_col;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [CHAR_W-1:0]      cell_char;
        logic [CHAR_W-1:0]      cell_attr;
        logic                   scrolled;
    } out_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] attr;
        logic [TAB_W-1:0]  tab_width;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } cmd_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    // back end control toward the front end
    typedef struct packed {
        logic pop;
        logic hold;
    } back_ctl_t;

    // logical row to storage row, rows rotate on scroll
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS))
            sum = sum - (ROW_W+1)'(ROWS);
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS)) + ADDR_W'(col);
    endfunction

endpackage

/* sv/text_console_writer.sv */
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+--------------------------
// in       | input     | in_valid / in_ready    | in_data  (in_item_t)
// out      | output    | out_valid / out_ready  | out_data (out_item_t)
// cfg      | input     | cfg_we                 | cfg_index, cfg_data
//
// after reset the screen store is cleared one cell a cycle, in_ready low
//   meanwhile; cfg writes are taken at any time
// back end per item: a printable or line control is handled in idle, a read adds
//   a read state, a tab writes tab_width spaces, a scroll blanks the COLS (80) new bottom row cells
// the front end queues up to QUEUE_DEPTH classified items, so input is still taken
//   while the back end scrolls or the output is stalled, until the queue is full
// the back end starts an item only when its result register is free
module text_console_writer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tcw_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tcw_pkg::out_item_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import tcw_pkg::*;

    // configuration registers
    logic [CHAR_W-1:0] attr_reg;
    logic [TAB_W-1:0]  tab_reg;
    cfg_t              cfg;

    // front to back link
    queue_head_t       head;
    back_ctl_t         ctl;

    // writes beyond the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
            tab_reg  <= RESET_TAB;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ATTR)
                attr_reg <= cfg_data[CHAR_W-1:0];
            else if (cfg_index == CFG_TAB)
                tab_reg <= cfg_data[TAB_W-1:0];
        end
    end

    assign cfg.attr      = attr_reg;
    assign cfg.tab_width = tab_reg;

    // front end: classifies each transfer and queues it
    tcw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .ctl      (ctl),
        .head     (head)
    );

    // back end: cursor, screen store, scroll sweep and result register
    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .ctl       (ctl),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* sv/tcw_ram.sv */
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tcw_front.sv */
module tcw_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcw_pkg::in_item_t   in_data,
    input  tcw_pkg::back_ctl_t  ctl,
    output tcw_pkg::queue_head_t head
);

    import tcw_pkg::*;

    cmd_t              cmd_in;
    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    // classify the incoming item
    always_comb
    begin
        cmd_in.ch  = in_data.char_code;
        cmd_in.row = ROW_W'(in_data.read_row);
        cmd_in.col = COL_W'(in_data.read_col);
        if (in_data.action)
        begin
            if ((int'(in_data.read_row) < ROWS) && (int'(in_data.read_col) < COLS))
                cmd_in.op = OP_READ;
            else
                cmd_in.op = OP_NONE;
        end
        else if ((in_data.char_code == CH_NL) || (in_data.char_code == CH_CR))
            cmd_in.op = OP_LINE;
        else if (in_data.char_code == CH_TAB)
            cmd_in.op = OP_TAB;
        else
            cmd_in.op = OP_PRINT;
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH)) && !ctl.hold;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (ctl.pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !ctl.pop)
            count_next = count_reg + 1'b1;
        else if (!push && ctl.pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (count_reg != '0))
        else $error("command queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count overflow");

endmodule

/* sv/tcw_back.sv */
module tcw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::cfg_t        cfg,
    input  tcw_pkg::queue_head_t head,
    output tcw_pkg::back_ctl_t   ctl,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcw_pkg::out_item_t   out_data
);

    import tcw_pkg::*;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_TAB    = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [COL_W-1:0]  sweep_reg, sweep_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [TAB_W-1:0]  tab_cnt_reg, tab_cnt_next;
    logic              scr_reg, scr_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic              slot_free;
    logic              finish;
    logic [CHAR_W-1:0] res_char;
    logic [CHAR_W-1:0] res_attr;

    // cursor after one printed cell
    logic [COL_W-1:0]  adv_col;
    logic [ROW_W-1:0]  adv_row;
    logic              adv_scroll;
    // cursor after a line control
    logic [ROW_W-1:0]  nl_row;
    logic              nl_scroll;

    logic              at_last_row;
    assign at_last_row = (row_reg == ROW_W'(ROWS - 1));

    always_comb
    begin
        nl_scroll = at_last_row;
        nl_row    = at_last_row ? row_reg : row_reg + 1'b1;
        if (col_reg == COL_W'(COLS - 1))
        begin
            adv_col    = '0;
            adv_row    = nl_row;
            adv_scroll = nl_scroll;
        end
        else
        begin
            adv_col    = col_reg + 1'b1;
            adv_row    = row_reg;
            adv_scroll = 1'b0;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sweep_next     = sweep_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        top_next       = top_reg;
        tab_cnt_next   = tab_cnt_reg;
        scr_next       = scr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr(phys_row(row_reg, top_reg), col_reg);
        mem_wdata      = {cfg.attr, CH_SPACE};
        mem_raddr      = cell_addr(phys_row(head.cmd.row, top_reg), head.cmd.col);
        ctl.pop        = 1'b0;
        ctl.hold       = (state_reg == ST_INIT);
        finish         = 1'b0;
        res_char       = '0;
        res_attr       = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = RESET_CELL;
                if (clr_reg == ADDR_W'(CELLS - 1))
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end

            ST_IDLE:
            begin
                if (head.valid && slot_free)
                begin
                    ctl.pop    = 1'b1;
                    scr_next   = 1'b0;
                    sweep_next = '0;
                    priority case (head.cmd.op)
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        OP_LINE:
                        begin
                            col_next = '0;
                            row_next = nl_row;
                            if (nl_scroll)
                            begin
                                scr_next     = 1'b1;
                                tab_cnt_next = '0;
                                state_next   = ST_SCROLL;
                            end
                            else
                                finish = 1'b1;
                        end
                        OP_PRINT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {cfg.attr, head.cmd.ch};
                            col_next  = adv_col;
                            row_next  = adv_row;
                            if (adv_scroll)
                            begin
                                scr_next     = 1'b1;
                                tab_cnt_next = '0;
                                state_next   = ST_SCROLL;
                            end
                            else
                                finish = 1'b1;
                        end
                        OP_TAB:
                        begin
                            tab_cnt_next = cfg.tab_width;
                            if (cfg.tab_width == '0)
                                finish = 1'b1;
                            else
                                state_next = ST_TAB;
                        end
                        default:
                        begin
                            // read outside the screen: zero cell
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                res_char   = mem_rdata[CHAR_W-1:0];
                res_attr   = mem_rdata[CELL_W-1:CHAR_W];
                finish     = 1'b1;
                state_next = ST_IDLE;
            end

            ST_TAB:
            begin
                mem_we       = 1'b1;
                col_next     = adv_col;
                row_next     = adv_row;
                tab_cnt_next = tab_cnt_reg - 1'b1;
                if (adv_scroll)
                begin
                    scr_next   = 1'b1;
                    sweep_next = '0;
                    state_next = ST_SCROLL;
                end
                else if (tab_cnt_reg == TAB_W'(1))
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCROLL:
            begin
                // old top row becomes the blank bottom row
                mem_we     = 1'b1;
                mem_waddr  = cell_addr(top_reg, sweep_reg);
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == COL_W'(COLS - 1))
                begin
                    top_next = phys_row(top_reg, ROW_W'(1));
                    if (tab_cnt_reg != '0)
                        state_next = ST_TAB;
                    else
                    begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            out_valid_next      = 1'b1;
            out_next.cursor_col = COL_FIELD_W'(col_next);
            out_next.cursor_row = ROW_FIELD_W'(row_next);
            out_next.cell_char  = res_char;
            out_next.cell_attr  = res_attr;
            out_next.scrolled   = scr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_reg       <= '0;
            sweep_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            tab_cnt_reg   <= '0;
            scr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sweep_reg     <= sweep_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            tab_cnt_reg   <= tab_cnt_next;
            scr_reg       <= scr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(col_reg) < COLS) && (int'(row_reg) < ROWS) && (int'(top_reg) < ROWS))
        else $error("cursor or top row out of range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (state_reg == ST_IDLE))
        else $error("command taken outside idle");

    a_busy_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_TAB || state_reg == ST_SCROLL)
            |-> !out_valid_reg)
        else $error("result slot occupied during command");

    a_tab_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAB) |-> (tab_cnt_reg != '0))
        else $error("tab loop with no spaces left");

endmodule
